/* rtl/bmiws_pkg.sv */
package bmiws_pkg;

  localparam int MOD_BITS_DEF = 31;
  localparam int VAL_W        = 32;
  localparam int CFG_W        = 31;
  localparam int OUT_W        = 31;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_W-1:0] MODULUS_RESET = 31'd998244353;
  localparam logic [CFG_W-1:0] WEIGHT_RESET  = 31'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_MUL1,
    ST_MUL2,
    ST_ADD,
    ST_EXP,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

/* rtl/bmiws_modmul.sv */
module bmiws_modmul #(
  parameter int W  = bmiws_pkg::MOD_BITS_DEF,
  parameter int AW = bmiws_pkg::VAL_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [AW-1:0] op_a,
  input  logic [W-1:0]  op_b,
  input  logic [W-1:0]  modulus,
  output logic          done,
  output logic [W-1:0]  product
);

  localparam int CNT_W = (AW > 1) ? $clog2(AW) : 1;

  logic [AW-1:0]    a_sh_r;
  logic [W-1:0]     b_r;
  logic [W-1:0]     acc_r;
  logic [W-1:0]     acc_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [W+1:0]     sum_w;
  logic [W+1:0]     m1_w;
  logic [W+1:0]     m2_w;

  assign m1_w = (W+2)'(modulus);
  assign m2_w = {1'b0, modulus, 1'b0};

  always_comb begin
    sum_w = {1'b0, acc_r, 1'b0} + (a_sh_r[AW-1] ? (W+2)'(b_r) : '0);
    if (sum_w >= m2_w) begin
      acc_nxt = W'(sum_w - m2_w);
    end else if (sum_w >= m1_w) begin
      acc_nxt = W'(sum_w - m1_w);
    end else begin
      acc_nxt = W'(sum_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(AW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh_r <= op_a;
      b_r    <= op_b;
      acc_r  <= '0;
    end else if (busy_r) begin
      a_sh_r <= {a_sh_r[AW-2:0], 1'b0};
      acc_r  <= acc_nxt;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

/* rtl/batch_modular_inverse_weighted_sum.sv */
// Each item passes through three bit-serial modular multiply rounds over its
// 32 input bits, then an add state and the idle state before the next accept.
// An item marked last goes on to raise out_valid after MOD_BITS Fermat power rounds
// plus the final multiply; one item is in work at a time.
// Synchronous active-low reset restores modulus 998244353, weight base 1 and an empty run.
module batch_modular_inverse_weighted_sum #(
  parameter int MOD_BITS = bmiws_pkg::MOD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bmiws_pkg::VAL_W-1:0]      in_value,
  input  logic                             in_is_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bmiws_pkg::OUT_W-1:0]      out_weighted_sum,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bmiws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmiws_pkg::CFG_W-1:0]      cfg_data
);

  localparam int VW     = bmiws_pkg::VAL_W;
  localparam int ECNT_W = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;

  bmiws_pkg::state_t state_r, state_nxt;

  logic [MOD_BITS-1:0]        mod_r;
  logic [bmiws_pkg::CFG_W-1:0] k_r;
  logic [VW-1:0]              value_r;
  logic                       last_r;
  logic [MOD_BITS-1:0]        num_r, prod_r, pow_r, ared_r, kred_r, t2_r, er_r, ex_r;
  logic [MOD_BITS-1:0]        exp_r;
  logic [ECNT_W-1:0]          ecnt_r;
  logic                       go_r, go_nxt;
  logic                       out_valid_r;
  logic [bmiws_pkg::OUT_W-1:0] out_data_r;

  logic [MOD_BITS-1:0] m_eff, one_w, e_w, u0_p, u1_p, u0_b, u1_b, num_sum;
  logic [VW-1:0]       u0_a, u1_a;
  logic [MOD_BITS:0]   add_w;
  logic                u0_done, u1_done, u_done, out_free, exp_end;

  assign m_eff    = (mod_r < MOD_BITS'(2)) ? MOD_BITS'(1) : mod_r;
  assign one_w    = (m_eff > MOD_BITS'(1)) ? MOD_BITS'(1) : '0;
  assign e_w      = (m_eff >= MOD_BITS'(2)) ? (m_eff - MOD_BITS'(2)) : '0;
  assign u_done   = u0_done & u1_done;
  assign out_free = !out_valid_r || out_ready;
  assign exp_end  = (ecnt_r == ECNT_W'(MOD_BITS - 1));
  assign add_w    = {1'b0, num_r} + {1'b0, t2_r};
  assign num_sum  = (add_w >= {1'b0, m_eff}) ? MOD_BITS'(add_w - {1'b0, m_eff})
                                             : MOD_BITS'(add_w);

  bmiws_modmul #(.W(MOD_BITS), .AW(VW)) u_mul0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (go_r),
    .op_a    (u0_a),
    .op_b    (u0_b),
    .modulus (m_eff),
    .done    (u0_done),
    .product (u0_p)
  );

  bmiws_modmul #(.W(MOD_BITS), .AW(VW)) u_mul1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (go_r),
    .op_a    (u1_a),
    .op_b    (u1_b),
    .modulus (m_eff),
    .done    (u1_done),
    .product (u1_p)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bmiws_pkg::ST_IDLE: if (in_valid) state_nxt = bmiws_pkg::ST_RED;
      bmiws_pkg::ST_RED:  if (u_done) state_nxt = bmiws_pkg::ST_MUL1;
      bmiws_pkg::ST_MUL1: if (u_done) state_nxt = bmiws_pkg::ST_MUL2;
      bmiws_pkg::ST_MUL2: if (u_done) state_nxt = bmiws_pkg::ST_ADD;
      bmiws_pkg::ST_ADD:  state_nxt = last_r ? bmiws_pkg::ST_EXP : bmiws_pkg::ST_IDLE;
      bmiws_pkg::ST_EXP:  if (u_done && exp_end) state_nxt = bmiws_pkg::ST_FIN;
      bmiws_pkg::ST_FIN:  if (u_done) state_nxt = bmiws_pkg::ST_OUT;
      bmiws_pkg::ST_OUT:  if (out_free) state_nxt = bmiws_pkg::ST_IDLE;
      default:            state_nxt = bmiws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    u0_a     = VW'(er_r);
    u0_b     = ex_r;
    u1_a     = VW'(ex_r);
    u1_b     = ex_r;
    go_nxt   = 1'b0;
    unique case (state_r)
      bmiws_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        go_nxt   = in_valid;
      end
      bmiws_pkg::ST_RED: begin
        u0_a   = value_r;
        u0_b   = one_w;
        u1_a   = VW'(k_r);
        u1_b   = one_w;
        go_nxt = u_done;
      end
      bmiws_pkg::ST_MUL1: begin
        u0_a   = VW'(pow_r);
        u0_b   = kred_r;
        u1_a   = VW'(num_r);
        u1_b   = ared_r;
        go_nxt = u_done;
      end
      bmiws_pkg::ST_MUL2: begin
        u0_a = VW'(prod_r);
        u0_b = pow_r;
        u1_a = VW'(prod_r);
        u1_b = ared_r;
      end
      bmiws_pkg::ST_ADD: begin
        go_nxt = last_r;
      end
      bmiws_pkg::ST_EXP: begin
        go_nxt = u_done;
      end
      bmiws_pkg::ST_FIN: begin
        u0_a = VW'(num_r);
        u0_b = er_r;
      end
      bmiws_pkg::ST_OUT: begin
        go_nxt = 1'b0;
      end
      default: begin
        go_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmiws_pkg::ST_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      mod_r       <= MOD_BITS'(bmiws_pkg::MODULUS_RESET);
      k_r         <= bmiws_pkg::WEIGHT_RESET;
      num_r       <= '0;
      prod_r      <= MOD_BITS'(1);
      pow_r       <= MOD_BITS'(1);
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          bmiws_pkg::CFG_MODULUS: mod_r <= cfg_data[MOD_BITS-1:0];
          bmiws_pkg::CFG_WEIGHT:  k_r   <= cfg_data;
          default:                k_r   <= k_r;
        endcase
      end
      if (state_r == bmiws_pkg::ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (u_done) begin
        case (state_r)
          bmiws_pkg::ST_MUL1: begin
            pow_r <= u0_p;
            num_r <= u1_p;
          end
          bmiws_pkg::ST_MUL2: prod_r <= u1_p;
          bmiws_pkg::ST_FIN: begin
            num_r  <= '0;
            prod_r <= MOD_BITS'(1);
            pow_r  <= MOD_BITS'(1);
          end
          default: num_r <= num_r;
        endcase
      end
      if (state_r == bmiws_pkg::ST_ADD) begin
        num_r <= num_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      value_r <= in_value;
      last_r  <= in_is_last;
    end
    if (state_r == bmiws_pkg::ST_ADD) begin
      er_r   <= one_w;
      ex_r   <= prod_r;
      exp_r  <= e_w;
      ecnt_r <= '0;
    end
    if (u_done) begin
      case (state_r)
        bmiws_pkg::ST_RED: begin
          ared_r <= u0_p;
          kred_r <= u1_p;
        end
        bmiws_pkg::ST_MUL2: t2_r <= u0_p;
        bmiws_pkg::ST_EXP: begin
          if (exp_r[0]) begin
            er_r <= u0_p;
          end
          ex_r   <= u1_p;
          exp_r  <= exp_r >> 1;
          ecnt_r <= ecnt_r + ECNT_W'(1);
        end
        bmiws_pkg::ST_FIN: er_r <= u0_p;
        default: t2_r <= t2_r;
      endcase
    end
    if (state_r == bmiws_pkg::ST_OUT && out_free) begin
      out_data_r <= bmiws_pkg::OUT_W'(er_r);
    end
  end

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_weighted_sum = out_data_r;

  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    u0_done == u1_done)
    else $error("multiply units out of step");

  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    u_done |-> (state_r == bmiws_pkg::ST_RED || state_r == bmiws_pkg::ST_MUL1 ||
                state_r == bmiws_pkg::ST_MUL2 || state_r == bmiws_pkg::ST_EXP ||
                state_r == bmiws_pkg::ST_FIN))
    else $error("multiply finished outside a multiply phase");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bmiws_pkg::ST_OUT))
    else $error("result raised without final phase");

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bmiws_pkg::ST_IDLE) |-> !go_r || $past(state_r == bmiws_pkg::ST_ADD))
    else $error("multiply launched while idle");

endmodule
